[design/bswc_pkg.sv]
// shared types and constants for the bounded-spread window counter
package bswc_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LEN_W   = 32;
  localparam int TOTAL_W = 64;
  localparam int OUT_W   = LEN_W + TOTAL_W;
  localparam int POS_W   = 32;

  localparam int SPREAD_W = 6;
  localparam logic [SPREAD_W-1:0] MAX_SPREAD_RESET = 6'd2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // register index, taken from the word address bit
  localparam logic [0:0] REG_MAX_SPREAD = 1'b0;

  // operation on a whole deque
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_POP   = 2'd2,
    OP_PUSH  = 2'd3
  } deque_op_t;

  // operation seen by one cell of a deque
  typedef enum logic [1:0] {
    CC_HOLD  = 2'd0,
    CC_CLEAR = 2'd1,
    CC_SHIFT = 2'd2,
    CC_PUSH  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    deque_op_t        op;
    logic [POS_W-1:0] pos;
  } deque_ctrl_t;

endpackage

[design/bswc_cell.sv]
// one deque entry: holds (value, position), compares against the new sample
module bswc_cell #(
  parameter int SAMPLE_BITS = bswc_pkg::SAMPLE_BITS_DEF,
  parameter bit KEEP_MAX    = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bswc_pkg::cell_cmd_t           cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [bswc_pkg::POS_W-1:0]    pos_in,
  input  logic                          prev_keep,
  input  logic                          next_valid,
  input  logic signed [SAMPLE_BITS-1:0] next_val,
  input  logic [bswc_pkg::POS_W-1:0]    next_pos,
  output logic                          keep,
  output logic                          ent_valid,
  output logic signed [SAMPLE_BITS-1:0] ent_val,
  output logic [bswc_pkg::POS_W-1:0]    ent_pos
);

  logic hit;
  logic insert;

  // entry is dominated by the new sample and leaves from the back
  assign hit    = KEEP_MAX ? (ent_val <= sample) : (ent_val >= sample);
  assign keep   = ent_valid && !hit;
  assign insert = prev_keep && !keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else begin
      unique case (cmd)
        bswc_pkg::CC_HOLD:  ent_valid <= ent_valid;
        bswc_pkg::CC_CLEAR: ent_valid <= 1'b0;
        bswc_pkg::CC_SHIFT: ent_valid <= next_valid;
        bswc_pkg::CC_PUSH:  ent_valid <= keep || insert;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == bswc_pkg::CC_SHIFT) begin
      ent_val <= next_val;
      ent_pos <= next_pos;
    end else if (cmd == bswc_pkg::CC_PUSH && insert) begin
      ent_val <= sample;
      ent_pos <= pos_in;
    end
  end

endmodule

[design/bswc_deque.sv]
// monotonic deque as a row of cells, front at cell zero
module bswc_deque #(
  parameter int QUEUE_DEPTH = bswc_pkg::QUEUE_DEPTH_DEF,
  parameter int SAMPLE_BITS = bswc_pkg::SAMPLE_BITS_DEF,
  parameter bit KEEP_MAX    = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bswc_pkg::deque_ctrl_t         ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          front_valid,
  output logic signed [SAMPLE_BITS-1:0] front_val,
  output logic [bswc_pkg::POS_W-1:0]    front_pos
);

  logic                          link_keep  [QUEUE_DEPTH+1];
  logic                          link_valid [QUEUE_DEPTH+1];
  logic signed [SAMPLE_BITS-1:0] link_val   [QUEUE_DEPTH+1];
  logic [bswc_pkg::POS_W-1:0]    link_pos   [QUEUE_DEPTH+1];
  logic                          full_push;
  bswc_pkg::cell_cmd_t           cmd;

  // nothing left to pop from the back: drop the front and append at the end
  assign full_push = (ctrl.op == bswc_pkg::OP_PUSH) && link_keep[QUEUE_DEPTH];

  always_comb begin
    unique case (ctrl.op)
      bswc_pkg::OP_HOLD:  cmd = bswc_pkg::CC_HOLD;
      bswc_pkg::OP_CLEAR: cmd = bswc_pkg::CC_CLEAR;
      bswc_pkg::OP_POP:   cmd = bswc_pkg::CC_SHIFT;
      bswc_pkg::OP_PUSH:  cmd = full_push ? bswc_pkg::CC_SHIFT : bswc_pkg::CC_PUSH;
    endcase
  end

  assign link_keep[0]            = 1'b1;
  assign link_valid[QUEUE_DEPTH] = full_push;
  assign link_val[QUEUE_DEPTH]   = sample;
  assign link_pos[QUEUE_DEPTH]   = ctrl.pos;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    bswc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .KEEP_MAX   (KEEP_MAX)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .sample    (sample),
      .pos_in    (ctrl.pos),
      .prev_keep (link_keep[i]),
      .next_valid(link_valid[i+1]),
      .next_val  (link_val[i+1]),
      .next_pos  (link_pos[i+1]),
      .keep      (link_keep[i+1]),
      .ent_valid (link_valid[i]),
      .ent_val   (link_val[i]),
      .ent_pos   (link_pos[i])
    );
  end

  assign front_valid = link_valid[0];
  assign front_val   = link_val[0];
  assign front_pos   = link_pos[0];

endmodule

[design/bounded_spread_window_counter_core.sv]
// top level: bounded-spread window counter with max and min cell-chain deques
//
//   channel  | role        | transaction payload
//   ---------+-------------+---------------------------------------------------
//   s_axis   | sample in   | tdata: sample (signed), zero-filled to bytes
//            |             | tuser: restart
//   m_axis   | result out  | tdata: window_length [31:0], total_count [95:32]
//   apb      | config      | reg 0 at byte 0: max_spread [5:0], reset value 2
//
// an item passes from acceptance through the limit, push, shrink and finish
// states before its result is loaded; the shrink loop makes one front pop
// per cycle, at most the two deques' combined fill, and the next sample is
// taken only once the finish state has gone back to idle
// one item is in flight at a time; the output register lets the next sample
// be accepted while the previous result still waits on m_axis_tready
// rst is synchronous and active high; it empties both deques through their
// valid bits, zeroes positions and total, and sets max_spread to 2
// a stalled result holds the last step until the output register frees
module bounded_spread_window_counter_core #(
  parameter int QUEUE_DEPTH = bswc_pkg::QUEUE_DEPTH_DEF,
  parameter int SAMPLE_BITS = bswc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_axis_tdata: sample
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // s_axis_tuser: restart
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // m_axis_tdata: window_length, total_count
  output logic [bswc_pkg::OUT_W-1:0]            m_axis_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bswc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [bswc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bswc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int DIFF_W = (SAMPLE_BITS + 2 > bswc_pkg::SPREAD_W + 2) ?
                          SAMPLE_BITS + 2 : bswc_pkg::SPREAD_W + 2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LIMIT  = 5'b00010,
    ST_PUSH   = 5'b00100,
    ST_SHRINK = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [bswc_pkg::SPREAD_W-1:0]   max_spread;
  logic signed [SAMPLE_BITS-1:0]   sample_reg;
  logic [bswc_pkg::POS_W-1:0]      left_edge;
  logic [bswc_pkg::POS_W-1:0]      left_edge_next;
  logic [bswc_pkg::POS_W-1:0]      position;
  logic [bswc_pkg::LEN_W-1:0]      len_reg;
  logic [bswc_pkg::LEN_W-1:0]      len_next;
  logic [bswc_pkg::TOTAL_W-1:0]    total;
  logic [bswc_pkg::TOTAL_W-1:0]    total_next;
  logic [bswc_pkg::TOTAL_W:0]      total_sum;
  logic [bswc_pkg::LEN_W-1:0]      out_len;
  logic [bswc_pkg::TOTAL_W-1:0]    out_total;

  logic                            in_fire;
  logic                            out_free;
  logic                            cfg_write;
  logic [bswc_pkg::POS_W-1:0]      span;
  logic [bswc_pkg::POS_W-1:0]      off_max;
  logic [bswc_pkg::POS_W-1:0]      off_min;
  logic signed [DIFF_W-1:0]        spread_now;
  logic signed [DIFF_W-1:0]        spread_limit;
  logic                            too_wide;

  bswc_pkg::deque_ctrl_t           max_ctrl;
  bswc_pkg::deque_ctrl_t           min_ctrl;
  logic                            mx_valid;
  logic signed [SAMPLE_BITS-1:0]   mx_val;
  logic [bswc_pkg::POS_W-1:0]      mx_pos;
  logic                            mn_valid;
  logic signed [SAMPLE_BITS-1:0]   mn_val;
  logic [bswc_pkg::POS_W-1:0]      mn_pos;

  // handshakes
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {out_total, out_len};

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2:2] == bswc_pkg::REG_MAX_SPREAD);
  assign prdata    = (paddr[2:2] == bswc_pkg::REG_MAX_SPREAD) ?
                     {{(bswc_pkg::APB_DATA_W-bswc_pkg::SPREAD_W){1'b0}}, max_spread} :
                     '0;

  // offsets from the left edge make every order test immune to wrap
  assign span    = position - left_edge;
  assign off_max = mx_pos - left_edge;
  assign off_min = mn_pos - left_edge;

  // front max minus front min against the allowed spread
  assign spread_now   = DIFF_W'(mx_val) - DIFF_W'(mn_val);
  assign spread_limit = $signed({{(DIFF_W-bswc_pkg::SPREAD_W){1'b0}}, max_spread});
  assign too_wide     = mx_valid && mn_valid && (spread_now > spread_limit);

  // saturating running total
  assign total_sum  = {1'b0, total} +
                      {{(bswc_pkg::TOTAL_W+1-bswc_pkg::LEN_W){1'b0}}, len_reg};
  assign total_next = total_sum[bswc_pkg::TOTAL_W] ? '1 :
                      total_sum[bswc_pkg::TOTAL_W-1:0];

  always_comb begin
    state_next     = state;
    left_edge_next = left_edge;
    len_next       = len_reg;
    max_ctrl.op    = bswc_pkg::OP_HOLD;
    max_ctrl.pos   = position;
    min_ctrl.op    = bswc_pkg::OP_HOLD;
    min_ctrl.pos   = position;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          // restart empties both deques before this sample is used
          if (s_axis_tuser[0]) begin
            max_ctrl.op    = bswc_pkg::OP_CLEAR;
            min_ctrl.op    = bswc_pkg::OP_CLEAR;
            left_edge_next = '0;
          end
          state_next = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        // window about to reach 2^32 samples: slide the left edge by one
        if (&span) begin
          left_edge_next = left_edge + 1'b1;
          if (mx_valid && mx_pos == left_edge) begin
            max_ctrl.op = bswc_pkg::OP_POP;
          end
          if (mn_valid && mn_pos == left_edge) begin
            min_ctrl.op = bswc_pkg::OP_POP;
          end
        end
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        max_ctrl.op = bswc_pkg::OP_PUSH;
        min_ctrl.op = bswc_pkg::OP_PUSH;
        state_next  = ST_SHRINK;
      end
      ST_SHRINK: begin
        // drop whichever extreme is older, one per cycle
        if (too_wide && off_max < off_min) begin
          left_edge_next = mx_pos + 1'b1;
          max_ctrl.op    = bswc_pkg::OP_POP;
        end else if (too_wide && off_min < off_max) begin
          left_edge_next = mn_pos + 1'b1;
          min_ctrl.op    = bswc_pkg::OP_POP;
        end else begin
          len_next   = span + 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_spread    <= bswc_pkg::MAX_SPREAD_RESET;
      left_edge     <= '0;
      position      <= '0;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      left_edge <= left_edge_next;
      if (cfg_write) begin
        max_spread <= pwdata[bswc_pkg::SPREAD_W-1:0];
      end
      if (in_fire && s_axis_tuser[0]) begin
        position <= '0;
        total    <= '0;
      end else if (state == ST_FINISH && out_free) begin
        position <= position + 1'b1;
        total    <= total_next;
      end
      if (state == ST_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    len_reg <= len_next;
    if (state == ST_FINISH && out_free) begin
      out_len   <= len_reg;
      out_total <= total_next;
    end
  end

  // max deque keeps strictly decreasing values
  bswc_deque #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .KEEP_MAX   (1'b1)
  ) u_max_deque (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (max_ctrl),
    .sample     (sample_reg),
    .front_valid(mx_valid),
    .front_val  (mx_val),
    .front_pos  (mx_pos)
  );

  // min deque keeps strictly increasing values
  bswc_deque #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .KEEP_MAX   (1'b0)
  ) u_min_deque (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (min_ctrl),
    .sample     (sample_reg),
    .front_valid(mn_valid),
    .front_val  (mn_val),
    .front_pos  (mn_pos)
  );

endmodule

[design/bswc_checker.sv]
// port-level checks for the bounded-spread window counter, bound to the top
module bswc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bswc_pkg::OUT_W-1:0]   m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every window holds at least the current sample
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:0] != 32'd0)
    else $error("zero window length");

  // the total already includes this window
  a_total_covers_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[95:32] >= {32'd0, m_axis_tdata[31:0]})
    else $error("total below window length");

  // one sample in flight: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

endmodule

bind bounded_spread_window_counter_core bswc_checker u_bswc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
